@@ rtl/core/ndds_pkg.sv @@
// Shared types, constants and character helpers of the delimiter scanner.
// No dependencies; ndds_front, ndds_back, the top level and the testbench import this package.
`default_nettype none
package ndds_pkg;

  localparam int unsigned MaxNestDefault    = 16;
  localparam int unsigned KeywordMaxDefault = 31;

  localparam logic [2:0] STATUS_SCAN     = 3'd0;
  localparam logic [2:0] STATUS_NEST_OK  = 3'd1;
  localparam logic [2:0] STATUS_NEST_BAD = 3'd2;
  localparam logic [2:0] STATUS_TOP_OK   = 3'd3;
  localparam logic [2:0] STATUS_TOP_BAD  = 3'd4;
  localparam logic [2:0] STATUS_ABORT    = 3'd5;

  localparam logic [7:0] CHAR_LBRACE    = 8'h7b;
  localparam logic [7:0] CHAR_RBRACE    = 8'h7d;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_COMMA     = 8'h2c;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
    logic       is_bs;
    logic       is_lb;
    logic       is_rb;
    logic       is_comma;
    logic       is_space;
    logic       is_digit;
    logic       is_nl;
  } byte_class_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  nest_level;
    logic [31:0] closing_id;
  } scan_result_t;

  function automatic logic [7:0] begin_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h62;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h67;
      4'd3:    c = 8'h69;
      4'd4:    c = 8'h6e;
      4'd5:    c = 8'h64;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h65;
      4'd1:    c = 8'h6e;
      4'd2:    c = 8'h64;
      4'd3:    c = 8'h64;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h74;
      4'd6:    c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ndds_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ndds_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/ndds_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// No dependencies; used between the scanner stages and at the result side.
`default_nettype none
module ndds_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ndds_front.sv @@
// Front end: accepts raw bytes and classifies them into a decoded transaction.
// Depends on ndds_pkg and ndds_fifo.
`default_nettype none
module ndds_front
  import ndds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  input  wire logic        pop_i,
  output byte_class_t      item_o,
  output logic             empty_o
);

  byte_class_t cls;

  always_comb begin
    cls.eof      = end_of_file_i;
    cls.data     = data_byte_i;
    cls.is_bs    = (data_byte_i == CHAR_BACKSLASH);
    cls.is_lb    = (data_byte_i == CHAR_LBRACE);
    cls.is_rb    = (data_byte_i == CHAR_RBRACE);
    cls.is_comma = (data_byte_i == CHAR_COMMA);
    cls.is_space = (data_byte_i == CHAR_SPACE) ||
                   (data_byte_i >= 8'd9 && data_byte_i <= 8'd13);
    cls.is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
    cls.is_nl    = (data_byte_i == CHAR_NEWLINE);
  end

  ndds_fifo #(
    .Width($bits(byte_class_t)),
    .Depth(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cls),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(item_o),
    .empty_o(empty_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/ndds_back.sv @@
// Back end: keyword and id scanner state machine with the open-id stack.
// Depends on ndds_pkg and ndds_ram.
`default_nettype none
module ndds_back
  import ndds_pkg::*;
#(
  parameter int unsigned MaxNest    = MaxNestDefault,
  parameter int unsigned KeywordMax = KeywordMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] top_id_i,
  input  wire logic        fire_i,
  input  byte_class_t      item_i,
  output scan_result_t     result_o
);

  localparam int unsigned DW  = $clog2(MaxNest + 1);
  localparam int unsigned AW  = (MaxNest > 1) ? $clog2(MaxNest) : 1;
  localparam int unsigned KLW = $clog2(KeywordMax + 1);

  typedef enum logic [3:0] {
    PH_PLAIN, PH_SLASH, PH_KEYWORD, PH_BCLASS, PH_BSPACE, PH_BDIGITS, PH_BSKIP,
    PH_BNL, PH_ECLASS, PH_ESPACE, PH_EDIGITS, PH_ESKIP, PH_ENL
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [KLW-1:0] kl_q, kl_d;
  logic           mb_q, mb_d, me_q, me_d;
  logic [31:0]    acc_q, acc_d, acc_next;
  logic [DW-1:0]  depth_q, depth_d;
  logic [31:0]    stack_rdata, open_id, depth_ext;
  logic           push_en;
  logic [2:0]     status;
  logic [31:0]    closing;
  logic           restart;

  assign acc_next = (acc_q << 3) + (acc_q << 1) + {24'd0, item_i.data - CHAR_ZERO};

  ndds_ram #(
    .Width(32),
    .Depth(MaxNest)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (push_en),
    .waddr_i(AW'(depth_q)),
    .wdata_i(acc_q),
    .raddr_i(AW'(depth_q - DW'(1))),
    .rdata_o(stack_rdata)
  );

  assign open_id = (depth_q == '0) ? top_id_i : stack_rdata;

  always_comb begin
    phase_d = phase_q;
    kl_d    = kl_q;
    mb_d    = mb_q;
    me_d    = me_q;
    acc_d   = acc_q;
    depth_d = depth_q;
    push_en = 1'b0;
    status  = STATUS_SCAN;
    closing = '0;
    restart = 1'b0;
    if (item_i.eof) begin
      status  = STATUS_ABORT;
      restart = 1'b1;
    end else begin
      unique case (phase_q)
        PH_PLAIN: begin
          if (item_i.is_bs) phase_d = PH_SLASH;
        end
        PH_SLASH: begin
          if (item_i.is_lb || item_i.is_rb || item_i.is_bs) begin
            phase_d = PH_PLAIN;
          end else begin
            kl_d    = KLW'(1);
            mb_d    = (item_i.data == begin_char(4'd0));
            me_d    = (item_i.data == end_char(4'd0));
            phase_d = PH_KEYWORD;
          end
        end
        PH_KEYWORD: begin
          if (item_i.is_bs || item_i.is_rb) begin
            phase_d = item_i.is_bs ? PH_SLASH : PH_PLAIN;
          end else if (item_i.is_lb) begin
            if (mb_q && kl_q == KLW'(9)) phase_d = PH_BCLASS;
            else if (me_q && kl_q == KLW'(7)) phase_d = PH_ECLASS;
            else phase_d = PH_PLAIN;
          end else if (kl_q < KLW'(KeywordMax)) begin
            mb_d = mb_q && (kl_q < KLW'(9)) && (item_i.data == begin_char(kl_q[3:0]));
            me_d = me_q && (kl_q < KLW'(7)) && (item_i.data == end_char(kl_q[3:0]));
            kl_d = kl_q + KLW'(1);
          end
        end
        PH_BCLASS, PH_ECLASS: begin
          if (item_i.is_comma) begin
            acc_d   = '0;
            phase_d = (phase_q == PH_BCLASS) ? PH_BSPACE : PH_ESPACE;
          end
        end
        PH_BSPACE, PH_ESPACE, PH_BDIGITS, PH_EDIGITS: begin
          if ((phase_q == PH_BSPACE || phase_q == PH_ESPACE) && item_i.is_space) begin
            phase_d = phase_q;
          end else if (item_i.is_digit) begin
            acc_d   = acc_next;
            phase_d = (phase_q == PH_BSPACE || phase_q == PH_BDIGITS) ? PH_BDIGITS
                                                                      : PH_EDIGITS;
          end else if (item_i.is_rb) begin
            phase_d = (phase_q == PH_BSPACE || phase_q == PH_BDIGITS) ? PH_BNL : PH_ENL;
          end else begin
            phase_d = (phase_q == PH_BSPACE || phase_q == PH_BDIGITS) ? PH_BSKIP
                                                                      : PH_ESKIP;
          end
        end
        PH_BSKIP, PH_ESKIP: begin
          if (item_i.is_rb) phase_d = (phase_q == PH_BSKIP) ? PH_BNL : PH_ENL;
        end
        PH_BNL: begin
          if (depth_q >= DW'(MaxNest)) begin
            status  = STATUS_ABORT;
            restart = 1'b1;
          end else begin
            push_en = 1'b1;
            depth_d = depth_q + DW'(1);
            phase_d = item_i.is_bs ? PH_SLASH : PH_PLAIN;
          end
        end
        PH_ENL: begin
          closing = acc_q;
          if (depth_q == '0) begin
            status  = (open_id == acc_q) ? STATUS_TOP_OK : STATUS_TOP_BAD;
            restart = 1'b1;
          end else begin
            status  = (open_id == acc_q) ? STATUS_NEST_OK : STATUS_NEST_BAD;
            depth_d = depth_q - DW'(1);
          end
          phase_d = item_i.is_bs ? PH_SLASH : PH_PLAIN;
        end
        default: phase_d = PH_PLAIN;
      endcase
      if (restart) begin
        kl_d    = '0;
        mb_d    = 1'b1;
        me_d    = 1'b1;
        acc_d   = '0;
        depth_d = '0;
      end
    end
    if (item_i.eof) begin
      phase_d = PH_PLAIN;
      kl_d    = '0;
      mb_d    = 1'b1;
      me_d    = 1'b1;
      acc_d   = '0;
      depth_d = '0;
    end else if (restart && phase_q == PH_BNL) begin
      phase_d = PH_PLAIN;
    end
    push_en = push_en && fire_i;
  end

  assign depth_ext           = 32'(depth_d);
  assign result_o.status     = status;
  assign result_o.nest_level = depth_ext[4:0];
  assign result_o.closing_id = closing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      kl_q    <= '0;
      mb_q    <= 1'b1;
      me_q    <= 1'b1;
      acc_q   <= '0;
      depth_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kl_q    <= kl_d;
      mb_q    <= mb_d;
      me_q    <= me_d;
      acc_q   <= acc_d;
      depth_q <= depth_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nested_datastream_delimiter_scanner_core.sv @@
// Top level of the nested datastream delimiter scanner.
// Depends on ndds_pkg, ndds_front, ndds_back and ndds_fifo.
`default_nettype none
// Bytes enter through a push/full queue and one result per byte leaves through
// an empty/pop queue. One byte is taken every cycle while results are popped,
// since the front and the result side each have a two-entry queue. The open-id
// stack sits in a RAM whose read address follows the nesting depth, so the open
// id is already read out when a close is compared. top_id is written through
// the cfg_valid_i/cfg_ready_o channel, which is always ready.
module nested_datastream_delimiter_scanner_core
  import ndds_pkg::*;
#(
  parameter int unsigned MaxNest    = MaxNestDefault,
  parameter int unsigned KeywordMax = KeywordMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic      [2:0]  status_o,
  output logic      [4:0]  nest_level_o,
  output logic      [31:0] closing_id_o
);

  logic [31:0]  top_id_q;
  byte_class_t  item;
  logic         mid_empty, out_full, back_fire;
  scan_result_t back_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_id_q <= cfg_data_i;
    end
  end

  assign back_fire = !mid_empty && !out_full;

  ndds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .pop_i        (back_fire),
    .item_o       (item),
    .empty_o      (mid_empty)
  );

  ndds_back #(
    .MaxNest   (MaxNest),
    .KeywordMax(KeywordMax)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .top_id_i(top_id_q),
    .fire_i  (back_fire),
    .item_i  (item),
    .result_o(back_res)
  );

  ndds_fifo #(
    .Width($bits(scan_result_t)),
    .Depth(2)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_fire),
    .wdata_i(back_res),
    .full_o (out_full),
    .pop_i  (pop_i),
    .rdata_o(out_res),
    .empty_o(empty_o)
  );

  assign status_o     = out_res.status;
  assign nest_level_o = out_res.nest_level;
  assign closing_id_o = out_res.closing_id;

`ifndef SYNTHESIS
  a_closing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && (status_o == STATUS_SCAN || status_o == STATUS_ABORT)
      |-> closing_id_o == '0)
    else $error("closing id set without a close");
  a_top_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && (status_o == STATUS_TOP_OK || status_o == STATUS_TOP_BAD ||
                 status_o == STATUS_ABORT) |-> nest_level_o == '0)
    else $error("depth not cleared on restart");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> status_o <= STATUS_ABORT)
    else $error("status out of range");
`endif

endmodule
`default_nettype wire

@@ verif/nested_datastream_delimiter_scanner_core_tb.sv @@
// Self-checking testbench of the nested datastream delimiter scanner core.
// Needs ndds_pkg and the scanner RTL; drives byte streams and checks each result.
`timescale 1ns / 1ps
module nested_datastream_delimiter_scanner_core_tb;
  import ndds_pkg::*;

  localparam int unsigned NestMax = 16;
  localparam int unsigned KwMax   = 31;
  localparam int unsigned WatchdogLimit = 5000;

  typedef enum logic [3:0] {
    PH_PLAIN, PH_SLASH, PH_KEYWORD, PH_BCLASS, PH_BSPACE, PH_BDIGITS, PH_BSKIP,
    PH_BNL, PH_ECLASS, PH_ESPACE, PH_EDIGITS, PH_ESKIP, PH_ENL
  } phase_e;

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  level;
    logic [31:0] closing;
  } scan_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic push_i = 1'b0;
  logic full_o;
  logic [7:0] data_byte_i = '0;
  logic end_of_file_i = 1'b0;
  logic empty_o;
  logic pop_i = 1'b0;
  logic [2:0] status_o;
  logic [4:0] nest_level_o;
  logic [31:0] closing_id_o;

  nested_datastream_delimiter_scanner_core uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] top_id_q;
  phase_e      phase_q;
  int unsigned kw_len_q;
  bit          is_begin_q, is_end_q;
  logic [31:0] id_acc_q;
  logic [31:0] id_stack_q [NestMax];
  int unsigned depth_q;

  scan_out_t expected_q[$];
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned closes_seen = 0;
  int unsigned idle_stall = 1;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] begin_ch(int unsigned i);
    string s;
    s = "begindata";
    return s[i];
  endfunction

  function automatic logic [7:0] end_ch(int unsigned i);
    string s;
    s = "enddata";
    return s[i];
  endfunction

  function automatic void restart_scan();
    phase_q = PH_PLAIN;
    kw_len_q = 0;
    is_begin_q = 1'b1;
    is_end_q = 1'b1;
    id_acc_q = '0;
    depth_q = 0;
  endfunction

  function automatic bit scan_byte(logic [7:0] b, ref scan_out_t r);
    logic [31:0] open_id;
    case (phase_q)
      PH_PLAIN: begin
        if (b == CHAR_BACKSLASH) phase_q = PH_SLASH;
        return 0;
      end
      PH_SLASH: begin
        if (b == CHAR_LBRACE || b == CHAR_RBRACE || b == CHAR_BACKSLASH) begin
          phase_q = PH_PLAIN;
          return 0;
        end
        kw_len_q = 1;
        is_begin_q = (b == begin_ch(0));
        is_end_q = (b == end_ch(0));
        phase_q = PH_KEYWORD;
        return 0;
      end
      PH_KEYWORD: begin
        if (b == CHAR_BACKSLASH || b == CHAR_RBRACE) begin
          phase_q = PH_PLAIN;
          return 1;
        end
        if (b == CHAR_LBRACE) begin
          if (is_begin_q && kw_len_q == 9) phase_q = PH_BCLASS;
          else if (is_end_q && kw_len_q == 7) phase_q = PH_ECLASS;
          else phase_q = PH_PLAIN;
          return 0;
        end
        if (kw_len_q < KwMax) begin
          is_begin_q = is_begin_q && kw_len_q < 9 && b == begin_ch(kw_len_q < 9 ? kw_len_q : 0);
          is_end_q = is_end_q && kw_len_q < 7 && b == end_ch(kw_len_q < 7 ? kw_len_q : 0);
          kw_len_q++;
        end
        return 0;
      end
      PH_BCLASS, PH_ECLASS: begin
        if (b == CHAR_COMMA) begin
          id_acc_q = '0;
          phase_q = (phase_q == PH_BCLASS) ? PH_BSPACE : PH_ESPACE;
        end
        return 0;
      end
      PH_BSPACE, PH_ESPACE: begin
        if (b == CHAR_SPACE || (b >= 8'd9 && b <= 8'd13)) return 0;
        phase_q = (phase_q == PH_BSPACE) ? PH_BDIGITS : PH_EDIGITS;
        return 1;
      end
      PH_BDIGITS, PH_EDIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          id_acc_q = id_acc_q * 32'd10 + 32'(b - CHAR_ZERO);
          return 0;
        end
        if (b == CHAR_RBRACE) phase_q = (phase_q == PH_BDIGITS) ? PH_BNL : PH_ENL;
        else phase_q = (phase_q == PH_BDIGITS) ? PH_BSKIP : PH_ESKIP;
        return 0;
      end
      PH_BSKIP, PH_ESKIP: begin
        if (b == CHAR_RBRACE) phase_q = (phase_q == PH_BSKIP) ? PH_BNL : PH_ENL;
        return 0;
      end
      PH_BNL: begin
        if (depth_q >= NestMax) begin
          r.status = STATUS_ABORT;
          restart_scan();
          return 0;
        end
        id_stack_q[depth_q] = id_acc_q;
        depth_q++;
        phase_q = PH_PLAIN;
        return b != CHAR_NEWLINE;
      end
      PH_ENL: begin
        open_id = (depth_q >= 1) ? id_stack_q[depth_q - 1] : top_id_q;
        r.closing = id_acc_q;
        if (depth_q == 0) begin
          r.status = (open_id == id_acc_q) ? STATUS_TOP_OK : STATUS_TOP_BAD;
          restart_scan();
        end else begin
          r.status = (open_id == id_acc_q) ? STATUS_NEST_OK : STATUS_NEST_BAD;
          depth_q--;
          phase_q = PH_PLAIN;
        end
        return b != CHAR_NEWLINE;
      end
      default: begin
        phase_q = PH_PLAIN;
        return 0;
      end
    endcase
  endfunction

  function automatic scan_out_t predict_scan(logic [7:0] b, logic eof);
    scan_out_t r;
    int passes;
    r.status = STATUS_SCAN;
    r.closing = '0;
    passes = 0;
    if (eof) begin
      r.status = STATUS_ABORT;
      restart_scan();
    end else begin
      while (scan_byte(b, r) && passes < 3) passes++;
    end
    r.level = 5'(depth_q);
    return r;
  endfunction

  task automatic send_byte(logic [7:0] b, logic eof = 1'b0);
    while (idle_stall && $urandom_range(99) < 25) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (full_o);
    expected_q.push_back(predict_scan(b, eof));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    push_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_top_id(logic [31:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    top_id_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    scan_out_t e;
    if (rst_ni && pop_i && !empty_o) begin
      results_seen++;
      if (status_o != STATUS_SCAN) closes_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d level=%0d id=%0d", $time,
                 status_o, nest_level_o, closing_id_o);
        error_count++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          error_count++;
        end
        if (nest_level_o !== e.level) begin
          $display("%0t: level expected %0d actual %0d", $time, e.level, nest_level_o);
          error_count++;
        end
        if (closing_id_o !== e.closing) begin
          $display("%0t: closing id expected %0d actual %0d", $time, e.closing, closing_id_o);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk_i) pop_i <= !(idle_stall && $urandom_range(99) < 25);

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic string random_id_text();
    case ($urandom_range(3))
      0: return $sformatf("%0d", $urandom_range(9));
      1: return $sformatf("%0d", $urandom);
      2: return "99999999999";
      default: return $sformatf("%0d", $urandom_range(1000));
    endcase
  endfunction

  function automatic string random_filler();
    string s;
    int n;
    s = "";
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
    return s;
  endfunction

  task automatic test_escapes();
    send_text("ab\\{\\}\\\\x\\fo}\\ba\\zz{q");
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("\\k\\");
    send_text("n");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_nesting();
    send_text("\\begindata{t, 42}\n\\enddata{t,42}x");
    send_text("\\begindata{t,7xy}z\\enddata{t, 8}\n");
    send_text("\\begindata{t,}\n\\enddata{t,\t}\n");
    send_text("\\enddata{t,4294967295}q");
    send_text("\\enddata{t,5}\n");
    send_text("\\begindata{t,1}");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_long_keyword();
    send_text("\\begindataxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx{a,1}\n");
    send_text("\\enddat{a,1}\\begindat{a,1}\n");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 17; i++) send_text($sformatf("\\begindata{c,%0d}\n", i));
    send_text("\\begindata{c,99}");
    send_byte(8'h0a, 1'b1);
  endtask

  task automatic test_random_stream(int unsigned n);
    int unsigned start;
    int unsigned depth;
    start = bytes_sent;
    depth = 0;
    while (bytes_sent - start < n) begin
      case ($urandom_range(9))
        0, 1, 2: if (depth < 17) begin
          send_text({"\\begindata{c,", random_filler(), random_id_text(), "}"});
          if ($urandom_range(1)) send_byte(CHAR_NEWLINE);
          depth++;
        end
        3, 4, 5: begin
          send_text({"\\enddata{c,", $urandom_range(1) ? " " : "", random_id_text(),
                     random_filler(), "}"});
          if ($urandom_range(1)) send_byte(CHAR_NEWLINE);
          if (depth != 0) depth--;
        end
        6: send_text(random_filler());
        7: send_byte(8'($urandom));
        8: send_text({"\\", random_filler()});
        default: if ($urandom_range(5) == 0) begin
          send_byte(8'($urandom), 1'b1);
          depth = 0;
        end
      endcase
      if (depth_q == 0) depth = 0;
    end
  endtask

  initial begin
    restart_scan();
    top_id_q = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_escapes();
    test_nesting();
    write_top_id(32'd5);
    test_nesting();
    write_top_id(32'hffff_ffff);
    test_long_keyword();
    test_nesting();
    test_overflow();
    write_top_id(32'd0);
    idle_stall = 0;
    test_random_stream(100);
    idle_stall = 1;
    test_random_stream(100);
    write_top_id($urandom);
    test_random_stream(90);
    drain_results();
    $display("Run covered %0d bytes and %0d results, %0d of them closes or aborts.",
             bytes_sent, results_seen, closes_seen);
    $display("Escapes, keyword cuts, nesting overflow, eof and several top ids were exercised.");
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ndds_pkg.sv
rtl/core/ndds_ram.sv
rtl/core/ndds_fifo.sv
rtl/core/ndds_front.sv
rtl/core/ndds_back.sv
rtl/core/nested_datastream_delimiter_scanner_core.sv
verif/nested_datastream_delimiter_scanner_core_tb.sv
